### rtl/erac_pkg.sv
// Package with the beat types, register map and constants of the echo ranging classifier.
`default_nettype none

package erac_pkg;

    localparam int TICK_W = 17;
    localparam int DIST_W = 15;
    localparam int PRE_LOW_TICKS = 2;
    localparam int TRIG_HIGH_TICKS = 10;
    localparam int DIST_MUL = 11239;
    localparam int DIST_MUL_W = 14;
    localparam int DIST_SHIFT = 16;
    localparam int PROD_W = TICK_W + DIST_MUL_W;
    localparam int LIMIT10_W = 13;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_DETECT_LIMIT = 2'd0;
    localparam logic [1:0] REG_WARNING_LIMIT = 2'd1;
    localparam logic [1:0] REG_LIGHT_LIMIT = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    localparam logic [8:0] DETECT_LIMIT_RST = 9'd20;
    localparam logic [8:0] WARNING_LIMIT_RST = 9'd10;
    localparam logic [7:0] LIGHT_LIMIT_RST = 8'd30;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 17'd100000;

    localparam logic [1:0] STATUS_NORMAL = 2'd0;
    localparam logic [1:0] STATUS_DETECTED = 2'd1;
    localparam logic [1:0] STATUS_NEAR = 2'd2;
    localparam logic [1:0] STATUS_DARK = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic       echo_level;
        logic [7:0] light_value;
    } item_t;

    typedef struct packed {
        logic              trigger_level;
        logic              done_res;
        logic              failed;
        logic [DIST_W-1:0] distance_tenths;
        logic [1:0]        status_code;
        logic              busy_res;
    } result_t;

    typedef struct packed {
        logic [8:0]        detect_limit_cm;
        logic [8:0]        warning_limit_cm;
        logic [7:0]        light_limit;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/erac_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module erac_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [erac_pkg::ADDR_W-1:0] paddr,
    input  wire logic [erac_pkg::DATA_W-1:0] pwdata,
    output logic      [erac_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output erac_pkg::cfg_t                 cfg
);
    import erac_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_DETECT_LIMIT:  cfg_next.detect_limit_cm = pwdata[8:0];
                REG_WARNING_LIMIT: cfg_next.warning_limit_cm = pwdata[8:0];
                REG_LIGHT_LIMIT:   cfg_next.light_limit = pwdata[7:0];
                REG_TIMEOUT:       cfg_next.timeout_ticks = pwdata[TICK_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_limit_cm <= DETECT_LIMIT_RST;
            cfg_reg.warning_limit_cm <= WARNING_LIMIT_RST;
            cfg_reg.light_limit <= LIGHT_LIMIT_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DETECT_LIMIT:  prdata = DATA_W'(cfg_reg.detect_limit_cm);
            REG_WARNING_LIMIT: prdata = DATA_W'(cfg_reg.warning_limit_cm);
            REG_LIGHT_LIMIT:   prdata = DATA_W'(cfg_reg.light_limit);
            REG_TIMEOUT:       prdata = DATA_W'(cfg_reg.timeout_ticks);
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/erac_ranger.sv
// Trigger and echo timing state machine with distance and status classification.
`default_nettype none

module erac_ranger (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  erac_pkg::item_t      item,
    input  erac_pkg::cfg_t       cfg,
    output erac_pkg::result_t    result
);
    import erac_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_PRE  = 5'b00010,
        PH_TRIG = 5'b00100,
        PH_WAIT = 5'b01000,
        PH_MEAS = 5'b10000
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [TICK_W-1:0]   ticks_reg;
    logic [TICK_W-1:0]   ticks_next;
    phase_t              phase_eff;
    logic [TICK_W-1:0]   ticks_eff;
    logic [TICK_W-1:0]   ticks_inc;
    logic [PROD_W-1:0]   product;
    logic [DIST_W-1:0]   dist_tenths;
    logic [LIMIT10_W-1:0] warn10;
    logic [LIMIT10_W-1:0] detect10;
    logic                done;
    logic                fail;
    logic                measured;
    logic                trig;
    logic [1:0]          status;

    always_comb
    begin
        if (phase_reg == PH_IDLE && item.req_type)
        begin
            phase_eff = PH_PRE;
            ticks_eff = '0;
        end
        else
        begin
            phase_eff = phase_reg;
            ticks_eff = ticks_reg;
        end
    end

    assign ticks_inc = ticks_eff + TICK_W'(1);
    assign product = PROD_W'(ticks_eff) * PROD_W'(DIST_MUL);

    always_comb
    begin
        phase_next = phase_eff;
        ticks_next = ticks_eff;
        done = 1'b0;
        fail = 1'b0;
        measured = 1'b0;
        trig = 1'b0;
        unique case (phase_eff)
            PH_IDLE:
            begin
                ticks_next = ticks_eff;
            end
            PH_PRE:
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= TICK_W'(PRE_LOW_TICKS))
                begin
                    phase_next = PH_TRIG;
                    ticks_next = '0;
                end
            end
            PH_TRIG:
            begin
                trig = 1'b1;
                ticks_next = ticks_inc;
                if (ticks_inc >= TICK_W'(TRIG_HIGH_TICKS))
                begin
                    phase_next = PH_WAIT;
                    ticks_next = '0;
                end
            end
            PH_WAIT:
            begin
                priority if (item.echo_level)
                begin
                    phase_next = PH_MEAS;
                    ticks_next = TICK_W'(1);
                end
                else if (ticks_eff >= cfg.timeout_ticks)
                begin
                    done = 1'b1;
                    fail = 1'b1;
                end
                else
                begin
                    ticks_next = ticks_inc;
                end
            end
            PH_MEAS:
            begin
                priority if (!item.echo_level)
                begin
                    done = 1'b1;
                    measured = 1'b1;
                end
                else if (ticks_eff >= cfg.timeout_ticks)
                begin
                    done = 1'b1;
                    fail = 1'b1;
                end
                else
                begin
                    ticks_next = ticks_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase
        if (done)
        begin
            phase_next = PH_IDLE;
            ticks_next = '0;
        end
    end

    assign dist_tenths = measured ? product[DIST_SHIFT +: DIST_W] : '0;
    assign warn10 = (LIMIT10_W'(cfg.warning_limit_cm) << 3)
                  + (LIMIT10_W'(cfg.warning_limit_cm) << 1);
    assign detect10 = (LIMIT10_W'(cfg.detect_limit_cm) << 3)
                    + (LIMIT10_W'(cfg.detect_limit_cm) << 1);

    always_comb
    begin
        priority if (dist_tenths != '0 && dist_tenths < DIST_W'(warn10))
        begin
            status = STATUS_NEAR;
        end
        else if (dist_tenths != '0 && dist_tenths < DIST_W'(detect10))
        begin
            status = STATUS_DETECTED;
        end
        else if (item.light_value < cfg.light_limit)
        begin
            status = STATUS_DARK;
        end
        else
        begin
            status = STATUS_NORMAL;
        end
    end

    assign result.trigger_level = trig;
    assign result.done_res = done;
    assign result.failed = fail;
    assign result.distance_tenths = dist_tenths;
    assign result.status_code = done ? status : STATUS_NORMAL;
    assign result.busy_res = (phase_next != PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
        end
    end

`ifndef SYNTHESIS
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(ticks_reg))
        else $error("Ranging state changed without a beat.");

    a_fail_is_done_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.failed |-> result.done_res && result.distance_tenths == '0)
        else $error("Failed measurement without completion or with a distance.");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.done_res |=> phase_reg == PH_IDLE && ticks_reg == '0)
        else $error("Ranging state not idle after a completed measurement.");
`endif

endmodule

`default_nettype wire

### rtl/echo_ranging_alert_classifier.sv
// Top level of the ultrasonic echo ranging controller with alert classification.
// A tick beat passes through the input register and then the result register.
// Throughput: one tick beat per cycle while the result is not stalled, set by the input and result registers.
// The result register frees itself whenever its beat is taken, so a stalled
// result blocks input only once the input register is also full.
// Reset is asynchronous and active low; it empties both stages, idles the
// ranging state and loads the register defaults.
`default_nettype none

module echo_ranging_alert_classifier (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  erac_pkg::item_t                 item,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output erac_pkg::result_t               result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [erac_pkg::ADDR_W-1:0] paddr,
    input  wire logic [erac_pkg::DATA_W-1:0] pwdata,
    output logic      [erac_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import erac_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    logic    item_valid_next;
    result_t result_reg;
    result_t result_calc;
    logic    result_valid_reg;
    logic    result_valid_next;
    logic    out_free;
    logic    advance;
    logic    accept;

    assign out_free = !result_valid_reg || !result_stall;
    assign advance = item_valid_reg && out_free;
    assign item_stall = item_valid_reg && !out_free;
    assign accept = item_valid && !item_stall;

    assign item_valid_next = accept ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
    assign result_valid_next = advance ? 1'b1 : (result_valid_reg && result_stall);

    erac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    erac_ranger u_ranger (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_calc;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
